/* hdl/adci_pkg.sv */
// shared types, register codes and command constants of the ata dma command issuer
`timescale 1ns / 1ps

package adci_pkg;

  // default table geometry
  localparam int unsigned TABLE_ENTRIES_DEF     = 16;
  localparam int unsigned SECTORS_PER_ENTRY_DEF = 63;

  // field widths
  localparam int unsigned LBA_W    = 48;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned BC_W     = 16;
  localparam int unsigned OFF_W    = 4;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned SECTOR_SHIFT = 9;  // 512-byte sectors

  // microprogram geometry
  localparam int unsigned PC_W     = 5;
  localparam int unsigned UC_DEPTH = 18;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LBA48_ENABLE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_SECTORS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUSMASTER_ENABLE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE_ADDR  = 8'd3;

  // register offsets
  localparam logic [OFF_W-1:0] OFF_NONE     = 4'd0;
  localparam logic [OFF_W-1:0] OFF_BM_CMD   = 4'd0;
  localparam logic [OFF_W-1:0] OFF_BM_TABLE = 4'd4;
  localparam logic [OFF_W-1:0] OFF_TF_COUNT = 4'd2;
  localparam logic [OFF_W-1:0] OFF_TF_LBA_L = 4'd3;
  localparam logic [OFF_W-1:0] OFF_TF_LBA_M = 4'd4;
  localparam logic [OFF_W-1:0] OFF_TF_LBA_H = 4'd5;
  localparam logic [OFF_W-1:0] OFF_TF_DEV   = 4'd6;
  localparam logic [OFF_W-1:0] OFF_TF_CMD   = 4'd7;

  // command and control bytes
  localparam logic [7:0] CMD_RD28 = 8'hC8;
  localparam logic [7:0] CMD_WR28 = 8'hCA;
  localparam logic [7:0] CMD_RD48 = 8'h25;
  localparam logic [7:0] CMD_WR48 = 8'h35;
  localparam logic [7:0] DEV_BASE = 8'hE0;
  localparam logic [7:0] BM_START = 8'h01;
  localparam logic [7:0] BM_RESET = 8'h04;
  localparam logic [7:0] BM_READ  = 8'h08;
  localparam logic [LBA_W:0] LBA28_LIMIT = 49'h0_0000_1000_0000;  // last lba + 1
  localparam int unsigned LBA28_MAX_COUNT = 256;

  typedef enum logic [1:0] {
    TGT_PRD    = 2'd0,
    TGT_BM     = 2'd1,
    TGT_TF     = 2'd2,
    TGT_STATUS = 2'd3
  } tgt_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    COND_NONE   = 2'd0,
    COND_ERR    = 2'd1,
    COND_NARROW = 2'd2,
    COND_MORE   = 2'd3
  } cond_e;

  typedef enum logic [3:0] {
    SEL_ZERO     = 4'd0,
    SEL_PRD      = 4'd1,
    SEL_BM_RESET = 4'd2,
    SEL_TABLE    = 4'd3,
    SEL_DEV      = 4'd4,
    SEL_CNT_HI   = 4'd5,
    SEL_LBA_24   = 4'd6,
    SEL_LBA_32   = 4'd7,
    SEL_LBA_40   = 4'd8,
    SEL_CNT_LO   = 4'd9,
    SEL_LBA_0    = 4'd10,
    SEL_LBA_8    = 4'd11,
    SEL_LBA_16   = 4'd12,
    SEL_CMD      = 4'd13,
    SEL_BM_START = 4'd14
  } sel_e;

  // one microcode control word
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             done;
    logic             calc;
    logic             chk;
    cond_e            cond;
    logic [PC_W-1:0]  jaddr;
    tgt_e             tgt;
    logic [OFF_W-1:0] off;
    sel_e             sel;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic   fire;
    ucode_t word;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic err;
    logic narrow;
    logic more;
    logic out_free;
  } flags_t;

  typedef struct packed {
    logic               func;
    logic [LBA_W-1:0]   start_lba;
    logic [COUNT_W-1:0] sector_count;
    logic               drive_select;
    logic [ADDR_W-1:0]  buffer_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]        target;
    logic [OFF_W-1:0]  reg_offset;
    logic [ADDR_W-1:0] data_value;
    logic [BC_W-1:0]   prd_byte_count;
    logic              prd_end;
    logic [1:0]        status;
    logic              last;
  } res_t;

endpackage

/* hdl/adci_if.sv */
// request, result and configuration channel interfaces
`timescale 1ns / 1ps

interface adci_req_if;
  logic          valid;
  logic          ready;
  adci_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adci_res_if;
  logic          valid;
  logic          ready;
  adci_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adci_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [adci_pkg::CFG_IDX_W-1:0]      index;
  logic [adci_pkg::CFG_DATA_W-1:0]     wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* hdl/adci_sequencer.sv */
// microprogram rom, step counter and branch logic
`timescale 1ns / 1ps

module adci_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  adci_pkg::flags_t flags_i,
  output logic             req_ready_o,
  output adci_pkg::ctrl_t  ctrl_o
);

  localparam logic [adci_pkg::PC_W-1:0] UC_PRD    = 5'd2;
  localparam logic [adci_pkg::PC_W-1:0] UC_LBA28  = 5'd11;
  localparam logic [adci_pkg::PC_W-1:0] UC_ERR    = 5'd17;
  localparam logic [adci_pkg::PC_W-1:0] UC_NOJUMP = 5'd0;

  // emit, last, done, calc, chk, cond, jaddr, tgt, off, sel
  localparam adci_pkg::ucode_t ROM [adci_pkg::UC_DEPTH] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_STATUS, adci_pkg::OFF_NONE, adci_pkg::SEL_ZERO},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, adci_pkg::COND_ERR, UC_ERR,
      adci_pkg::TGT_STATUS, adci_pkg::OFF_NONE, adci_pkg::SEL_ZERO},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_MORE, UC_PRD,
      adci_pkg::TGT_PRD, adci_pkg::OFF_NONE, adci_pkg::SEL_PRD},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_BM, adci_pkg::OFF_BM_CMD, adci_pkg::SEL_BM_RESET},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_BM, adci_pkg::OFF_BM_TABLE, adci_pkg::SEL_TABLE},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_DEV, adci_pkg::SEL_DEV},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NARROW, UC_LBA28,
      adci_pkg::TGT_STATUS, adci_pkg::OFF_NONE, adci_pkg::SEL_ZERO},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_COUNT, adci_pkg::SEL_CNT_HI},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_LBA_L, adci_pkg::SEL_LBA_24},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_LBA_M, adci_pkg::SEL_LBA_32},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_LBA_H, adci_pkg::SEL_LBA_40},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_COUNT, adci_pkg::SEL_CNT_LO},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_LBA_L, adci_pkg::SEL_LBA_0},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_LBA_M, adci_pkg::SEL_LBA_8},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_LBA_H, adci_pkg::SEL_LBA_16},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_TF, adci_pkg::OFF_TF_CMD, adci_pkg::SEL_CMD},
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_BM, adci_pkg::OFF_BM_CMD, adci_pkg::SEL_BM_START},
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, adci_pkg::COND_NONE, UC_NOJUMP,
      adci_pkg::TGT_STATUS, adci_pkg::OFF_NONE, adci_pkg::SEL_ZERO}
  };

  logic                      busy_q, busy_d;
  logic [adci_pkg::PC_W-1:0] pc_q, pc_d;
  adci_pkg::ucode_t          word;
  logic                      stall;
  logic                      taken;

  assign word  = ROM[pc_q];
  // a word that writes waits until the result register is free
  assign stall = word.emit && !flags_i.out_free;

  always_comb begin
    case (word.cond)
      adci_pkg::COND_NONE:   taken = 1'b0;
      adci_pkg::COND_ERR:    taken = flags_i.err;
      adci_pkg::COND_NARROW: taken = flags_i.narrow;
      adci_pkg::COND_MORE:   taken = flags_i.more;
      default:               taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (busy_q && !stall) begin
      if (word.done) begin
        busy_d = 1'b0;
      end else if (taken) begin
        pc_d = word.jaddr;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign req_ready_o = !busy_q;
  assign ctrl_o.fire = busy_q && !stall;
  assign ctrl_o.word = word;

endmodule

/* hdl/adci_datapath.sv */
// request registers, configuration registers, checks, descriptor walk and result register
`timescale 1ns / 1ps

module adci_datapath #(
  parameter int unsigned TABLE_ENTRIES     = adci_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned SECTORS_PER_ENTRY = adci_pkg::SECTORS_PER_ENTRY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  adci_pkg::req_t                      req_i,
  input  logic                                cfg_we_i,
  input  logic [adci_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [adci_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  adci_pkg::ctrl_t                     ctrl_i,
  output adci_pkg::flags_t                    flags_o,
  input  logic                                res_ready_i,
  output logic                                res_valid_o,
  output adci_pkg::res_t                      res_o
);

  localparam int unsigned MAX_SECTORS = TABLE_ENTRIES * SECTORS_PER_ENTRY;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SPE_W = $clog2(SECTORS_PER_ENTRY + 1);
  localparam int unsigned LBA_W = adci_pkg::LBA_W;
  localparam int unsigned CNT_W = adci_pkg::COUNT_W;
  localparam int unsigned ADR_W = adci_pkg::ADDR_W;

  // configuration
  logic              lba48_q;
  logic [LBA_W-1:0]  cap_q;
  logic              bm_q;
  logic [ADR_W-1:0]  tbase_q;

  // request and walk state
  logic              func_q;
  logic [LBA_W-1:0]  lba_q;
  logic [CNT_W-1:0]  count_q;
  logic              drv_q;
  logic [ADR_W-1:0]  addr_q;
  logic [CNT_W-1:0]  left_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LBA_W:0]    sum_q;
  adci_pkg::status_e status_q;
  logic              wide_q;

  adci_pkg::res_t    res_q, res_d;
  logic              res_valid_q;

  adci_pkg::status_e status_c;
  logic              wide_c;
  logic              invalid_c;
  logic              more;
  logic [SPE_W-1:0]  sect;
  logic [ADR_W-1:0]  sect_bytes;
  logic              out_free;
  logic              load;
  logic [7:0]        byte_c;
  logic [7:0]        cmd_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lba48_q <= 1'b0;
      cap_q   <= '0;
      bm_q    <= 1'b0;
      tbase_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        adci_pkg::REG_LBA48_ENABLE:     lba48_q <= cfg_wdata_i[0];
        adci_pkg::REG_CAPACITY_SECTORS: cap_q   <= cfg_wdata_i[LBA_W-1:0];
        adci_pkg::REG_BUSMASTER_ENABLE: bm_q    <= cfg_wdata_i[0];
        adci_pkg::REG_TABLE_BASE_ADDR:  tbase_q <= cfg_wdata_i[ADR_W-1:0];
        default: ;
      endcase
    end
  end

  // request checks, from the sum registered one step earlier
  assign wide_c    = lba48_q && (lba_q[LBA_W-1:28] != '0);
  assign invalid_c = (count_q == '0) || !bm_q ||
                     ((cap_q != '0) && (sum_q > {1'b0, cap_q}));

  always_comb begin
    if (invalid_c) begin
      status_c = adci_pkg::ST_INVALID;
    end else if (32'(count_q) > MAX_SECTORS) begin
      status_c = adci_pkg::ST_TOO_MANY;
    end else if (!wide_c && (32'(count_q) > adci_pkg::LBA28_MAX_COUNT)) begin
      status_c = adci_pkg::ST_TOO_MANY;
    end else if (!wide_c && (sum_q > adci_pkg::LBA28_LIMIT)) begin
      status_c = adci_pkg::ST_INVALID;
    end else begin
      status_c = adci_pkg::ST_OK;
    end
  end

  // descriptor walk
  assign more       = left_q > CNT_W'(SECTORS_PER_ENTRY);
  assign sect       = more ? SPE_W'(SECTORS_PER_ENTRY) : left_q[SPE_W-1:0];
  assign sect_bytes = ADR_W'(sect) << adci_pkg::SECTOR_SHIFT;

  assign out_free = !res_valid_q || res_ready_i;
  assign load     = ctrl_i.fire && ctrl_i.word.emit;

  always_comb begin
    if (wide_q) begin
      cmd_c = func_q ? adci_pkg::CMD_WR48 : adci_pkg::CMD_RD48;
    end else begin
      cmd_c = func_q ? adci_pkg::CMD_WR28 : adci_pkg::CMD_RD28;
    end
  end

  always_comb begin
    case (ctrl_i.word.sel)
      adci_pkg::SEL_BM_RESET: byte_c = adci_pkg::BM_RESET;
      adci_pkg::SEL_DEV:      byte_c = adci_pkg::DEV_BASE |
                                       {3'b000, drv_q, lba_q[27:24]};
      adci_pkg::SEL_CNT_HI:   byte_c = 8'(count_q >> 8);
      adci_pkg::SEL_LBA_24:   byte_c = lba_q[31:24];
      adci_pkg::SEL_LBA_32:   byte_c = lba_q[39:32];
      adci_pkg::SEL_LBA_40:   byte_c = lba_q[47:40];
      adci_pkg::SEL_CNT_LO:   byte_c = count_q[7:0];
      adci_pkg::SEL_LBA_0:    byte_c = lba_q[7:0];
      adci_pkg::SEL_LBA_8:    byte_c = lba_q[15:8];
      adci_pkg::SEL_LBA_16:   byte_c = lba_q[23:16];
      adci_pkg::SEL_CMD:      byte_c = cmd_c;
      adci_pkg::SEL_BM_START: byte_c = adci_pkg::BM_START |
                                       (func_q ? 8'h00 : adci_pkg::BM_READ);
      default:                byte_c = 8'h00;
    endcase
  end

  always_comb begin
    res_d                = '0;
    res_d.target         = 2'(ctrl_i.word.tgt);
    res_d.reg_offset     = ctrl_i.word.off;
    res_d.status         = 2'(status_q);
    res_d.last           = ctrl_i.word.last;
    case (ctrl_i.word.sel)
      adci_pkg::SEL_PRD: begin
        res_d.reg_offset     = 4'(idx_q);
        res_d.data_value     = addr_q;
        res_d.prd_byte_count = adci_pkg::BC_W'(sect_bytes) - 1'b1;
        res_d.prd_end        = !more;
      end
      adci_pkg::SEL_TABLE: res_d.data_value = tbase_q;
      adci_pkg::SEL_ZERO:  res_d.data_value = '0;
      default:             res_d.data_value = ADR_W'(byte_c);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      func_q  <= req_i.func;
      lba_q   <= req_i.start_lba;
      count_q <= req_i.sector_count;
      drv_q   <= req_i.drive_select;
      addr_q  <= req_i.buffer_addr;
      left_q  <= req_i.sector_count;
      idx_q   <= '0;
    end else if (ctrl_i.fire) begin
      if (ctrl_i.word.sel == adci_pkg::SEL_PRD) begin
        addr_q <= addr_q + sect_bytes;
        left_q <= left_q - CNT_W'(sect);
        idx_q  <= idx_q + 1'b1;
      end
    end
    if (ctrl_i.fire && ctrl_i.word.calc) begin
      sum_q <= (LBA_W + 1)'(lba_q) + (LBA_W + 1)'(count_q);
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= adci_pkg::ST_OK;
      wide_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.fire && ctrl_i.word.chk) begin
        status_q <= status_c;
        wide_q   <= wide_c;
      end
      if (load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign flags_o.err      = status_c != adci_pkg::ST_OK;
  assign flags_o.narrow   = !wide_q;
  assign flags_o.more     = more;
  assign flags_o.out_free = out_free;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* hdl/ata_dma_command_issuer_unit.sv */
// top level of the ata bus-master dma command issuer
// one request at a time; the microprogram runs one control word per cycle while the result
//   register is free: 2 check steps, a word per descriptor entry, a mode branch step and 9
//   (lba28) or 13 (lba48) register words
// a rejected request gives its single status word as the word after the check steps
// a stalled result register holds the sequencer; request ready returns after the last word
// reset (asynchronous, active low) clears the sequencer, result valid and all config registers
`timescale 1ns / 1ps

module ata_dma_command_issuer_unit #(
  parameter int unsigned TABLE_ENTRIES     = adci_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned SECTORS_PER_ENTRY = adci_pkg::SECTORS_PER_ENTRY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  adci_req_if.sink    req_i,
  adci_res_if.source  res_o,
  adci_cfg_if.sink    cfg_i
);

  adci_pkg::flags_t flags;
  adci_pkg::ctrl_t  ctrl;
  logic             req_ready;
  logic             start;

  assign start       = req_i.valid && req_ready;
  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  adci_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .flags_i     (flags),
    .req_ready_o (req_ready),
    .ctrl_o      (ctrl)
  );

  adci_datapath #(
    .TABLE_ENTRIES     (TABLE_ENTRIES),
    .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_wdata_i (cfg_i.wdata),
    .ctrl_i      (ctrl),
    .flags_o     (flags),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_o       (res_o.data)
  );

endmodule

/* hdl/adci_checker.sv */
// port-level checks of the command issuer and their binding
`timescale 1ns / 1ps

module adci_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input adci_pkg::res_t res_data_i
);

  // one request in flight: ready drops right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a request is in flight");

  // a status-only result ends its request and carries an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.target == 2'(adci_pkg::TGT_STATUS)) |->
      res_data_i.last && (res_data_i.status != 2'(adci_pkg::ST_OK)))
    else $error("status result without last or error code");

  // errors only travel in status-only results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.target != 2'(adci_pkg::TGT_STATUS)) |->
      res_data_i.status == 2'(adci_pkg::ST_OK))
    else $error("error status on a register write");

  // end mark and byte count only on descriptor entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.target != 2'(adci_pkg::TGT_PRD)) |->
      !res_data_i.prd_end && (res_data_i.prd_byte_count == '0))
    else $error("descriptor fields set on a non-descriptor word");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("stalled result changed");

endmodule

bind ata_dma_command_issuer_unit adci_checker u_adci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

/* dv/ata_dma_command_issuer_unit_tb.sv */
// self-checking testbench of the ata dma command issuer: predicted write runs vs. dut output
`timescale 1ns / 1ps

module ata_dma_command_issuer_unit_tb;
  import adci_pkg::*;

  localparam int unsigned HALF_PERIOD = 4;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd9;
  localparam int unsigned MAX_SECTORS = TABLE_ENTRIES_DEF * SECTORS_PER_ENTRY_DEF;

  // predicts the register and descriptor writes of each request and checks the dut's words
  class dma_cmd_scoreboard;
    logic        lba48_en;
    logic [47:0] capacity;
    logic        bm_en;
    logic [31:0] table_base;
    res_t        write_run_q[$];
    int unsigned n_requests, n_wide, n_narrow, n_rejected, n_words, n_fail;

    function new();
      lba48_en   = 1'b0;
      capacity   = '0;
      bm_en      = 1'b0;
      table_base = '0;
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LBA48_ENABLE:     lba48_en = val[0];
        REG_CAPACITY_SECTORS: capacity = val[47:0];
        REG_BUSMASTER_ENABLE: bm_en = val[0];
        REG_TABLE_BASE_ADDR:  table_base = val[31:0];
        default: ;
      endcase
    endfunction

    function void push_word(tgt_e t, logic [OFF_W-1:0] off, logic [31:0] d,
                            logic [15:0] bc, logic e, status_e st, logic l);
      res_t w;
      w.target         = t;
      w.reg_offset     = off;
      w.data_value     = d;
      w.prd_byte_count = bc;
      w.prd_end        = e;
      w.status         = st;
      w.last           = l;
      write_run_q.push_back(w);
    endfunction

    function void reject(status_e st);
      n_rejected++;
      push_word(TGT_STATUS, OFF_NONE, '0, '0, 1'b0, st, 1'b1);
    endfunction

    function void note_request(req_t r);
      logic [48:0] span_end;
      logic [31:0] addr;
      logic [7:0]  dev;
      logic [7:0]  cmd;
      logic [3:0]  idx;
      int unsigned left, chunk;
      logic        wide;
      n_requests++;
      span_end = {1'b0, r.start_lba} + 49'(r.sector_count);
      if (r.sector_count == 0 || !bm_en) begin
        reject(ST_INVALID);
        return;
      end
      if (capacity != 0 && span_end > {1'b0, capacity}) begin
        reject(ST_INVALID);
        return;
      end
      if (r.sector_count > MAX_SECTORS) begin
        reject(ST_TOO_MANY);
        return;
      end
      wide = lba48_en && (r.start_lba > 48'h0FFF_FFFF);
      if (!wide) begin
        if (r.sector_count > LBA28_MAX_COUNT) begin
          reject(ST_TOO_MANY);
          return;
        end
        // last sector must stay inside 28-bit reach
        if (span_end > LBA28_LIMIT) begin
          reject(ST_INVALID);
          return;
        end
      end
      if (wide) n_wide++;
      else n_narrow++;

      left = r.sector_count;
      addr = r.buffer_addr;
      idx  = '0;
      while (left > 0) begin
        chunk = (left > SECTORS_PER_ENTRY_DEF) ? SECTORS_PER_ENTRY_DEF : left;
        push_word(TGT_PRD, idx, addr, 16'((chunk << SECTOR_SHIFT) - 1), left == chunk,
                  ST_OK, 1'b0);
        addr = addr + 32'(chunk << SECTOR_SHIFT);
        left = left - chunk;
        idx  = idx + 4'd1;
      end

      push_word(TGT_BM, OFF_BM_CMD, 32'(BM_RESET), '0, 1'b0, ST_OK, 1'b0);
      push_word(TGT_BM, OFF_BM_TABLE, table_base, '0, 1'b0, ST_OK, 1'b0);
      dev = DEV_BASE | {3'b000, r.drive_select, r.start_lba[27:24]};
      push_word(TGT_TF, OFF_TF_DEV, 32'(dev), '0, 1'b0, ST_OK, 1'b0);
      if (wide) begin
        push_word(TGT_TF, OFF_TF_COUNT, 32'(r.sector_count[9:8]), '0, 1'b0, ST_OK, 1'b0);
        push_word(TGT_TF, OFF_TF_LBA_L, 32'(r.start_lba[31:24]), '0, 1'b0, ST_OK, 1'b0);
        push_word(TGT_TF, OFF_TF_LBA_M, 32'(r.start_lba[39:32]), '0, 1'b0, ST_OK, 1'b0);
        push_word(TGT_TF, OFF_TF_LBA_H, 32'(r.start_lba[47:40]), '0, 1'b0, ST_OK, 1'b0);
      end
      // a count of 256 goes out as a zero byte
      push_word(TGT_TF, OFF_TF_COUNT, 32'(r.sector_count[7:0]), '0, 1'b0, ST_OK, 1'b0);
      push_word(TGT_TF, OFF_TF_LBA_L, 32'(r.start_lba[7:0]), '0, 1'b0, ST_OK, 1'b0);
      push_word(TGT_TF, OFF_TF_LBA_M, 32'(r.start_lba[15:8]), '0, 1'b0, ST_OK, 1'b0);
      push_word(TGT_TF, OFF_TF_LBA_H, 32'(r.start_lba[23:16]), '0, 1'b0, ST_OK, 1'b0);
      if (wide) cmd = r.func ? CMD_WR48 : CMD_RD48;
      else cmd = r.func ? CMD_WR28 : CMD_RD28;
      push_word(TGT_TF, OFF_TF_CMD, 32'(cmd), '0, 1'b0, ST_OK, 1'b0);
      push_word(TGT_BM, OFF_BM_CMD, 32'(BM_START | (r.func ? 8'h00 : BM_READ)), '0, 1'b0,
                ST_OK, 1'b1);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        n_fail++;
        $display("%0t: word %0d %s mismatch, expected %0h, actual %0h",
                 $time, n_words, name, want, seen);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (write_run_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        return;
      end
      want = write_run_q.pop_front();
      compare_field("target", 32'(want.target), 32'(got.target));
      compare_field("reg_offset", 32'(want.reg_offset), 32'(got.reg_offset));
      compare_field("data_value", want.data_value, got.data_value);
      compare_field("prd_byte_count", 32'(want.prd_byte_count), 32'(got.prd_byte_count));
      compare_field("prd_end", 32'(want.prd_end), 32'(got.prd_end));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("last", 32'(want.last), 32'(got.last));
      n_words++;
    endfunction

    function int unsigned outstanding();
      return write_run_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  adci_req_if req_if();
  adci_res_if res_if();
  adci_cfg_if cfg_if();

  dma_cmd_scoreboard sb = new();

  int unsigned res_stall_pct = 0;
  int unsigned res_hold = 0;
  logic        quiet = 1'b0;

  ata_dma_command_issuer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  function automatic req_t mk_req(logic f, logic [47:0] lba, logic [9:0] cnt, logic drv,
                                  logic [31:0] baddr);
    req_t r;
    r.func         = f;
    r.start_lba    = lba;
    r.sector_count = cnt;
    r.drive_select = drv;
    r.buffer_addr  = baddr;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    logic [63:0] rnd;
    longint unsigned room;
    int unsigned pick;
    r.func         = 1'($urandom_range(0, 1));
    r.drive_select = 1'($urandom_range(0, 1));
    r.buffer_addr  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 55) r.sector_count = 10'($urandom_range(1, 70));
    else if (pick < 78) r.sector_count = 10'($urandom_range(1, 256));
    else if (pick < 94) r.sector_count = 10'($urandom_range(1, MAX_SECTORS));
    else r.sector_count = 10'($urandom_range(0, 1023));
    // lba28 drives mostly get counts they can take
    if (!sb.lba48_en && r.sector_count > LBA28_MAX_COUNT && $urandom_range(0, 3) != 0)
      r.sector_count = 10'($urandom_range(1, LBA28_MAX_COUNT));
    rnd = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0, 1: r.start_lba = 48'(rnd[27:0]);
      2: r.start_lba = rnd[47:0];
      default: r.start_lba = 48'h0FFF_FFFF - 48'($urandom_range(0, 300));
    endcase
    // keep most requests inside the drive
    if (sb.capacity != 0 && sb.capacity >= 48'(r.sector_count) && $urandom_range(0, 9) != 0)
    begin
      room = 64'(sb.capacity) - 64'(r.sector_count);
      r.start_lba = 48'(rnd % (room + 1));
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    forever begin
      @(posedge clk_i);
      if (req_if.ready === 1'b1) break;
    end
    sb.note_request(r);
  endtask

  task automatic req_gap(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
  endtask

  // drop the request, then wait out every pending word and some slack
  task automatic drain(input int unsigned extra);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_if.ready === 1'b1) break;
    end
    sb.apply_config(idx, val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_all(input logic l48, input logic [47:0] cap, input logic bm,
                             input logic [31:0] base);
    drain(20);
    cfg_write(REG_LBA48_ENABLE, CFG_DATA_W'(l48));
    cfg_write(REG_CAPACITY_SECTORS, CFG_DATA_W'(cap));
    cfg_write(REG_BUSMASTER_ENABLE, CFG_DATA_W'(bm));
    cfg_write(REG_TABLE_BASE_ADDR, CFG_DATA_W'(base));
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned gap_pct);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (!quiet && $urandom_range(0, 99) < gap_pct) req_gap($urandom_range(1, 15));
      send_req(random_request());
    end
  endtask

  // result side: random stall bursts, the long hold-off, and a free-running tail
  initial begin : result_sink
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (res_hold != 0) begin
        res_hold--;
        res_if.ready <= 1'b0;
      end else if (quiet) begin
        res_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < res_stall_pct) begin
        stall_left = $urandom_range(0, 14);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) sb.check_result(res_if.data);
    end
  end

  initial begin : stimulus
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    rst_ni       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    res_stall_pct = 10;

    // no engine after reset
    send_req(mk_req(1'b0, 48'd100, 10'd8, 1'b0, 32'h0000_1000));
    send_req(mk_req(1'b1, 48'd0, 10'd1, 1'b1, 32'h0));

    // lba28 drive, no range check, top table address
    program_all(1'b0, 48'd0, 1'b1, 32'hFFFF_FFFF);
    cfg_write(REG_UNMAPPED, '1);
    send_req(mk_req(1'b0, 48'd0, 10'd1, 1'b0, 32'h0));
    send_req(mk_req(1'b1, 48'h0000_0123_4567, 10'd256, 1'b1, 32'h8000_0000));
    send_req(mk_req(1'b0, 48'd10, 10'd257, 1'b0, 32'h0));
    send_req(mk_req(1'b1, 48'd10, 10'd0, 1'b0, 32'h0));
    send_req(mk_req(1'b0, 48'h0000_0FFF_FFFF, 10'd1, 1'b1, 32'h0000_0200));
    send_req(mk_req(1'b1, 48'h0000_0FFF_FFFF, 10'd2, 1'b0, 32'h0));
    send_req(mk_req(1'b0, 48'hFFFF_FFFF_FFFF, 10'd4, 1'b0, 32'h0));
    req_gap(3);
    send_req(mk_req(1'b1, 48'd500, 10'd63, 1'b0, 32'h0001_0000));
    send_req(mk_req(1'b0, 48'd500, 10'd64, 1'b1, 32'h0001_0000));
    send_req(mk_req(1'b1, 48'd7, 10'd100, 1'b0, 32'hFFFF_FF00));
    send_req(mk_req(1'b0, 48'd7, 10'd1008, 1'b0, 32'h0));

    // lba48 drive
    program_all(1'b1, 48'd0, 1'b1, 32'h0);
    send_req(mk_req(1'b1, 48'h0000_1000_0000, 10'd1008, 1'b0, 32'hFFFF_FFFF));
    send_req(mk_req(1'b0, 48'hFFFF_FFFF_FFFF, 10'd1, 1'b1, 32'h0));
    send_req(mk_req(1'b0, 48'h0000_0FFF_FFFF, 10'd300, 1'b0, 32'h0));
    send_req(mk_req(1'b1, 48'h0000_1000_0000, 10'd1009, 1'b1, 32'h0));
    send_req(mk_req(1'b0, 48'hABCD_EF01_2345, 10'd1023, 1'b0, 32'h0));
    send_req(mk_req(1'b0, 48'h5A5A_A5A5_5A5A, 10'd700, 1'b1, 32'h1234_5678));

    // capacity edges
    program_all(1'b1, 48'd1000, 1'b1, 32'hDEAD_BEE0);
    send_req(mk_req(1'b0, 48'd990, 10'd10, 1'b0, 32'h0));
    send_req(mk_req(1'b1, 48'd990, 10'd11, 1'b0, 32'h0));
    program_all(1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, $urandom);
    send_req(mk_req(1'b1, 48'hFFFF_FFFF_FFFF, 10'd1, 1'b0, 32'h0));
    send_req(mk_req(1'b0, 48'hFFFF_FFFF_FFFE, 10'd1, 1'b1, 32'h0));

    // random: result side held off while requests pile up, then a full pause
    program_all(1'b1, 48'd0, 1'b1, $urandom);
    res_stall_pct = 25;
    res_hold = 300;
    repeat (6) send_req(random_request());
    run_random(8, 30);
    drain(0);
    run_random(10, 30);

    // lba28 drive with a range check, no idling on either side
    program_all(1'b0, 48'h0800_0000 + 48'($urandom_range(0, 32'h0FFF_FFFF)), 1'b1, $urandom);
    res_stall_pct = 0;
    run_random(25, 0);

    // large drive, heavy idling
    program_all(1'b1, {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)}, 1'b1, $urandom);
    res_stall_pct = 50;
    run_random(25, 60);

    // tail without idling
    program_all(1'b1, 48'd0, 1'b1, $urandom);
    quiet = 1'b1;
    run_random(20, 0);

    drain(40);
    $display("summary: %0d requests (%0d lba48, %0d lba28, %0d rejected), %0d words checked",
             sb.n_requests, sb.n_wide, sb.n_narrow, sb.n_rejected, sb.n_words);
    if (sb.n_fail == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

/* ata_dma_command_issuer_unit.f */
hdl/adci_pkg.sv
hdl/adci_if.sv
hdl/adci_sequencer.sv
hdl/adci_datapath.sv
hdl/ata_dma_command_issuer_unit.sv
hdl/adci_checker.sv
dv/ata_dma_command_issuer_unit_tb.sv
